// ===== hw/rtl/pvlc_pkg.sv =====
// Package for the PID valve level controller: widths, reset values,
// register indexes and the structs passed between the pipeline modules.
// Depends on nothing; every other file of the block refers to it.
`default_nettype none

package pvlc_pkg;

  localparam int unsigned LEVEL_W  = 10;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned ERR_W    = 11;
  localparam int unsigned DERR_W   = 12;
  localparam int unsigned PPROD_W  = GAIN_W + ERR_W;
  localparam int unsigned DPROD_W  = GAIN_W + DERR_W;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned VALVE_W  = 23;
  localparam int unsigned CTRL_W   = 24;
  localparam int unsigned PLANT_W  = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // 100.0 in Q16.16.
  localparam logic [VALVE_W-1:0] VALVE_FULL = 23'd6553600;

  localparam logic [INTEG_W-1:0] INTEG_MAX = 32'h7FFF_FFFF;
  localparam logic [INTEG_W-1:0] INTEG_MIN = 32'h8000_0000;

  localparam logic [LEVEL_W-1:0]       SETPOINT_RST = 10'd50;
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST   = 16'sd128;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST   = 16'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST   = 16'sd1280;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT       = 2'd0,
    CFG_GAIN_P         = 2'd1,
    CFG_GAIN_I_TS      = 2'd2,
    CFG_GAIN_D_OVER_TS = 2'd3
  } pvlc_cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]       setpoint;
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i_ts;
    logic signed [GAIN_W-1:0] gain_d_over_ts;
  } pvlc_cfg_t;

  // Raw gain products in Q8.8 (before the shift up to Q16.16).
  typedef struct packed {
    logic signed [PPROD_W-1:0] p_prod;
    logic signed [PPROD_W-1:0] i_prod;
    logic signed [DPROD_W-1:0] d_prod;
  } pvlc_prod_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pvlc_in_if.sv =====
// Input channel of the PID valve level controller: valid, ready and the
// measured level. Depends on pvlc_pkg for the field width.
`default_nettype none

interface pvlc_in_if;
  logic                         valid;
  logic                         ready;
  logic [pvlc_pkg::LEVEL_W-1:0] measured_level;

  modport source (output valid, output measured_level, input ready);
  modport sink (input valid, input measured_level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pvlc_out_if.sv =====
// Result channel of the PID valve level controller: valid, ready and the
// valve command fields. Depends on pvlc_pkg for the field widths.
`default_nettype none

interface pvlc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                close_step;
  logic [pvlc_pkg::PLANT_W-1:0]        step_amount;
  logic [pvlc_pkg::VALVE_W-1:0]        valve_position;
  logic signed [pvlc_pkg::CTRL_W-1:0]  control_value;

  modport source (output valid, output close_step, output step_amount,
                  output valve_position, output control_value, input ready);
  modport sink (input valid, input close_step, input step_amount,
                input valve_position, input control_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pid_valve_level_controller.sv =====
// PID valve level controller with conditional-integration anti-windup.
//
// Usage:
//   in_if carries one measured tank level per transfer (valid/ready).
//   out_if gives exactly one result per input: the step direction and size
//   for the plant valve, the commanded valve position (Q7.16, 0 to 100) and
//   the applied control increment (signed Q8.16).
//   cfg_we/cfg_index/cfg_wdata write setpoint, gain_p, gain_i_ts and
//   gain_d_over_ts; write them only while no sample is in flight.
// Timing:
//   Three register stages (error, gain products, loop update); an input passes
//   through them in that order, and one sample is taken every cycle while
//   in_if.ready is high. The loop state (integral, valve position, plant
//   valve) closes inside the last stage, which sets the one-cycle rate.
// Reset:
//   Synchronous, active low. Config registers return to their defaults, the
//   integral and valves to zero, integration is enabled and no result is held.
// Back-pressure:
//   When out_if.ready is low the result holds; earlier stages keep filling,
//   and in_if.ready drops only when every stage is occupied.
`default_nettype none

module pid_valve_level_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pvlc_in_if.sink                              in_if,
  pvlc_out_if.source                           out_if,
  input  wire logic                            cfg_we,
  input  wire logic [pvlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pvlc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pvlc_pkg::pvlc_cfg_t   cfg_r;
  pvlc_pkg::pvlc_prod_t  prod;
  logic                  prod_valid;
  logic                  prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= pvlc_pkg::SETPOINT_RST;
      cfg_r.gain_p         <= pvlc_pkg::GAIN_P_RST;
      cfg_r.gain_i_ts      <= pvlc_pkg::GAIN_I_RST;
      cfg_r.gain_d_over_ts <= pvlc_pkg::GAIN_D_RST;
    end else if (cfg_we) begin
      unique case (pvlc_pkg::pvlc_cfg_idx_t'(cfg_index))
        pvlc_pkg::CFG_SETPOINT: begin
          cfg_r.setpoint <= cfg_wdata[pvlc_pkg::LEVEL_W-1:0];
        end
        pvlc_pkg::CFG_GAIN_P: begin
          cfg_r.gain_p <= $signed(cfg_wdata);
        end
        pvlc_pkg::CFG_GAIN_I_TS: begin
          cfg_r.gain_i_ts <= $signed(cfg_wdata);
        end
        pvlc_pkg::CFG_GAIN_D_OVER_TS: begin
          cfg_r.gain_d_over_ts <= $signed(cfg_wdata);
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  pvlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_level   (in_if.measured_level),
    .prod_valid (prod_valid),
    .prod_ready (prod_ready),
    .prod       (prod)
  );

  pvlc_update u_update (
    .clk                (clk),
    .rst_n              (rst_n),
    .prod_valid         (prod_valid),
    .prod_ready         (prod_ready),
    .prod               (prod),
    .out_valid          (out_if.valid),
    .out_ready          (out_if.ready),
    .out_close_step     (out_if.close_step),
    .out_step_amount    (out_if.step_amount),
    .out_valve_position (out_if.valve_position),
    .out_control_value  (out_if.control_value)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pvlc_front.sv =====
// Front end of the controller: error and error change stage, then the
// registered gain multiplications. Depends on pvlc_pkg.
`default_nettype none

module pvlc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pvlc_pkg::pvlc_cfg_t          cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [pvlc_pkg::LEVEL_W-1:0] in_level,
  output logic                              prod_valid,
  input  wire logic                         prod_ready,
  output pvlc_pkg::pvlc_prod_t              prod
);

  logic                                  s1_valid_r;
  logic                                  s2_valid_r;
  logic                                  s1_ready;
  logic                                  s2_ready;
  logic                                  accept;
  logic signed [pvlc_pkg::ERR_W-1:0]     err_nxt;
  logic signed [pvlc_pkg::DERR_W-1:0]    err_ext;
  logic signed [pvlc_pkg::DERR_W-1:0]    derr_nxt;
  logic signed [pvlc_pkg::ERR_W-1:0]     err_r;
  logic signed [pvlc_pkg::DERR_W-1:0]    derr_r;
  logic signed [pvlc_pkg::DERR_W-1:0]    prev_err_r;
  logic signed [pvlc_pkg::PPROD_W-1:0]   p_prod_nxt;
  logic signed [pvlc_pkg::PPROD_W-1:0]   i_prod_nxt;
  logic signed [pvlc_pkg::DPROD_W-1:0]   d_prod_nxt;
  pvlc_pkg::pvlc_prod_t                  prod_r;

  assign s2_ready = !s2_valid_r || prod_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign accept   = in_valid && s1_ready;

  // Both operands are below 2^10, so the 11-bit wrapped difference is exact.
  always_comb begin
    err_nxt  = $signed({1'b0, cfg.setpoint} - {1'b0, in_level});
    err_ext  = {err_nxt[pvlc_pkg::ERR_W-1], err_nxt};
    derr_nxt = err_ext - prev_err_r;
  end

  always_comb begin
    p_prod_nxt = cfg.gain_p * err_r;
    i_prod_nxt = cfg.gain_i_ts * err_r;
    d_prod_nxt = cfg.gain_d_over_ts * derr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      prev_err_r <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (accept) begin
        prev_err_r <= err_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r  <= err_nxt;
      derr_r <= derr_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      prod_r.p_prod <= p_prod_nxt;
      prod_r.i_prod <= i_prod_nxt;
      prod_r.d_prod <= d_prod_nxt;
    end
  end

  assign prod_valid = s2_valid_r;
  assign prod       = prod_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pvlc_update.sv =====
// Loop update of the controller: integral with saturation, control sum,
// valve clamping with anti-windup and plant valve tracking, into the
// result register. Depends on pvlc_pkg.
`default_nettype none

module pvlc_update (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           prod_valid,
  output logic                                prod_ready,
  input  wire pvlc_pkg::pvlc_prod_t           prod,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_close_step,
  output logic [pvlc_pkg::PLANT_W-1:0]        out_step_amount,
  output logic [pvlc_pkg::VALVE_W-1:0]        out_valve_position,
  output logic signed [pvlc_pkg::CTRL_W-1:0]  out_control_value
);

  localparam int unsigned ISUM_W = pvlc_pkg::PPROD_W + 9;
  localparam int unsigned SUM_W  = pvlc_pkg::DPROD_W + 11;
  localparam int unsigned CSUM_W = SUM_W - 1;

  logic                                  take;
  logic                                  out_valid_r;
  logic                                  close_r;
  logic [pvlc_pkg::PLANT_W-1:0]          amount_r;
  logic [pvlc_pkg::VALVE_W-1:0]          valve_r;
  logic [pvlc_pkg::CTRL_W-1:0]           ctrl_r;

  logic [pvlc_pkg::INTEG_W-1:0]          integ_r;
  logic                                  int_en_r;
  logic [pvlc_pkg::VALVE_W-1:0]          cmd_r;
  logic [pvlc_pkg::PLANT_W-1:0]          plant_r;

  logic [ISUM_W-1:0]                     integ_sum;
  logic [pvlc_pkg::INTEG_W-1:0]          integ_sat;
  logic [pvlc_pkg::INTEG_W-1:0]          integ_nxt;
  logic [CSUM_W-1:0]                     control;
  logic [SUM_W-1:0]                      pos_sum;
  logic                                  hit_top;
  logic                                  hit_bottom;
  logic                                  int_en_nxt;
  logic [pvlc_pkg::VALVE_W-1:0]          cmd_nxt;
  logic [pvlc_pkg::CTRL_W-1:0]           ctrl_app;
  logic [pvlc_pkg::CTRL_W-1:0]           diff;
  logic [pvlc_pkg::CTRL_W-1:0]           abs_diff;
  logic [pvlc_pkg::PLANT_W-1:0]          amount;
  logic                                  close_nxt;
  logic [pvlc_pkg::PLANT_W-1:0]          plant_nxt;

  assign prod_ready = !out_valid_r || out_ready;
  assign take       = prod_valid && prod_ready;

  always_comb begin
    // Products are Q8.8 times integers; the shift by eight gives Q16.16.
    integ_sum = {{(ISUM_W - pvlc_pkg::INTEG_W){integ_r[pvlc_pkg::INTEG_W-1]}}, integ_r}
              + {prod.i_prod[pvlc_pkg::PPROD_W-1], prod.i_prod, 8'd0};
    priority if (integ_sum[ISUM_W-1:pvlc_pkg::INTEG_W-1] == '0 ||
                 integ_sum[ISUM_W-1:pvlc_pkg::INTEG_W-1] == '1) begin
      integ_sat = integ_sum[pvlc_pkg::INTEG_W-1:0];
    end else if (integ_sum[ISUM_W-1]) begin
      integ_sat = pvlc_pkg::INTEG_MIN;
    end else begin
      integ_sat = pvlc_pkg::INTEG_MAX;
    end
    integ_nxt = int_en_r ? integ_sat : integ_r;

    control = {{(CSUM_W - pvlc_pkg::PPROD_W - 8){prod.p_prod[pvlc_pkg::PPROD_W-1]}},
               prod.p_prod, 8'd0}
            + {{(CSUM_W - pvlc_pkg::INTEG_W){integ_nxt[pvlc_pkg::INTEG_W-1]}}, integ_nxt}
            + {{(CSUM_W - pvlc_pkg::DPROD_W - 8){prod.d_prod[pvlc_pkg::DPROD_W-1]}},
               prod.d_prod, 8'd0};
    pos_sum = {control[CSUM_W-1], control}
            + {{(SUM_W - pvlc_pkg::VALVE_W){1'b0}}, cmd_r};

    hit_top    = !pos_sum[SUM_W-1] &&
                 (pos_sum[CSUM_W-1:0] >= CSUM_W'(pvlc_pkg::VALVE_FULL));
    hit_bottom = pos_sum[SUM_W-1] || (pos_sum == '0);
    int_en_nxt = !(hit_top || hit_bottom);

    priority if (hit_top) begin
      cmd_nxt = pvlc_pkg::VALVE_FULL;
    end else if (hit_bottom) begin
      cmd_nxt = '0;
    end else begin
      cmd_nxt = pos_sum[pvlc_pkg::VALVE_W-1:0];
    end

    // The applied control is simply the change of the commanded position.
    ctrl_app = {1'b0, cmd_nxt} - {1'b0, cmd_r};

    // The plant valve in Q16.16 stays below 2^23, so 24 bits hold the difference.
    diff     = {1'b0, cmd_nxt} - {1'b0, plant_r, 16'd0};
    abs_diff = diff[pvlc_pkg::CTRL_W-1] ? (~diff + 1'b1) : diff;
    amount   = abs_diff[pvlc_pkg::VALVE_W-1:16];

    // The step direction follows the applied control, not the difference.
    close_nxt = (amount == '0) || ctrl_app[pvlc_pkg::CTRL_W-1];
    if (amount == '0) begin
      plant_nxt = plant_r;
    end else if (ctrl_app[pvlc_pkg::CTRL_W-1]) begin
      plant_nxt = plant_r - amount;
    end else begin
      plant_nxt = plant_r + amount;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      int_en_r    <= 1'b1;
      cmd_r       <= '0;
      plant_r     <= '0;
    end else begin
      if (prod_ready) begin
        out_valid_r <= prod_valid;
      end
      if (take) begin
        integ_r  <= integ_nxt;
        int_en_r <= int_en_nxt;
        cmd_r    <= cmd_nxt;
        plant_r  <= plant_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      close_r  <= close_nxt;
      amount_r <= amount;
      valve_r  <= cmd_nxt;
      ctrl_r   <= ctrl_app;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_close_step     = close_r;
  assign out_step_amount    = amount_r;
  assign out_valve_position = valve_r;
  assign out_control_value  = $signed(ctrl_r);

endmodule

`default_nettype wire

// ===== hw/rtl/pvlc_checker.sv =====
// Port-level checks for the PID valve level controller, bound to the top
// level. Depends on pvlc_pkg and on the result channel of the top level.
`default_nettype none

module pvlc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                close_step,
  input wire logic [pvlc_pkg::PLANT_W-1:0]        step_amount,
  input wire logic [pvlc_pkg::VALVE_W-1:0]        valve_position,
  input wire logic signed [pvlc_pkg::CTRL_W-1:0]  control_value
);

  localparam logic signed [pvlc_pkg::CTRL_W-1:0] CTRL_MAX =
    $signed({1'b0, pvlc_pkg::VALVE_FULL});
  localparam logic signed [pvlc_pkg::CTRL_W-1:0] CTRL_MIN = -CTRL_MAX;

  a_reset_clears_result: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_valve_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> valve_position <= pvlc_pkg::VALVE_FULL)
    else $error("valve position beyond full scale");

  a_control_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (control_value <= CTRL_MAX) && (control_value >= CTRL_MIN))
    else $error("applied control beyond one full stroke");

  a_no_move_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (step_amount == '0) |-> close_step)
    else $error("zero step not flagged as close");

endmodule

bind pid_valve_level_controller pvlc_checker u_pvlc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .close_step     (out_if.close_step),
  .step_amount    (out_if.step_amount),
  .valve_position (out_if.valve_position),
  .control_value  (out_if.control_value)
);

`default_nettype wire
